>>> src/ddo_pkg.sv
// Shared types, constants and tables for the differential drive odometry block.
// Used by ddo_mac, ddo_cordic, differential_drive_odometry and the testbench; depends on nothing.
package ddo_pkg;

  // Accumulator width: every product bit that the pose math reads lies below bit 80.
  localparam int AccW = 80;
  // Width of the rotation vector components; travel vectors stay below 2^57.
  localparam int XW = 60;
  // Width of the residual angle inside the rotator.
  localparam int ZW = 34;
  // Depth of the arctangent table and the bits that index it.
  localparam int AtanDepth = 32;
  localparam int AtanIdxW = $clog2(AtanDepth);

  localparam int CordicStepsDef = 24;

  // round(2^32 / pi) and the rotator gain compensation, Q0.32.
  localparam logic [31:0] InvPiBam = 32'd1367130551;
  localparam logic [31:0] CordicGain = 32'd2608131496;

  localparam logic [31:0] DistPerCountRst = 32'd2147484;
  localparam logic [31:0] InvTrackWidthRst = 32'd83886080;

  // Configuration register indexes.
  localparam logic REG_DIST_PER_COUNT = 1'b0;
  localparam logic REG_INV_TRACK_WIDTH = 1'b1;

  // Where a partial product lands in the accumulator.
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_32 = 2'd1,
    SH_64 = 2'd2
  } sh_sel_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic    mul;   // load the product register
    logic    acc;   // add the shifted product into the accumulator
    logic    clr;   // start a new sum instead of adding to the old one
    sh_sel_t sh;
  } mac_ctl_t;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic [31:0] atan_bam(input logic [AtanIdxW-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      5'd31: r = 32'h00000000;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> src/differential_drive_odometry.sv
// Top level of the differential drive odometry block: sequencer, pose state, output word.
// Depends on ddo_pkg, ddo_mac (shared multiplier) and ddo_cordic (rotator).
//
// Usage: each input word carries an operation and the absolute left and right
// encoder counts. Operation 0 turns the count differences since the last update
// into wheel travel, moves the pose along the midpoint heading and advances the
// heading; operation 1 zeroes pose and stored counts. Every input word yields
// exactly one output word holding x, y (Q16.16 metres) and the heading angle.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// The block takes one word at a time: in_stall is high from acceptance until
// the result has been placed in the output register. An update passes through
// the shared 32x32 multiplier (nine products plus bookkeeping), then the
// rotator, then saturation and publishing; a reset operation goes straight to
// publishing. The output register holds a finished word while out_stall is
// high; the next input word can already be taken then, and its result waits
// inside the block until the register is free. Reset clears pose, stored
// counts and handshake state and loads the configuration registers with their
// defaults. Configuration is written through cfg_write/cfg_index/cfg_data
// while idle; the user must keep to this, as the block itself does not enforce it.
module differential_drive_odometry
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] right_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x_out,
  output logic signed [31:0] pos_y_out,
  output logic signed [31:0] heading_out
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ROT  = 5'b00100,
    S_FIN  = 5'b01000,
    S_PUB  = 5'b10000
  } state_t;

  // Steps of the multiply phase. In each step the product is formed while phase
  // is low and accumulated while it is high, and the result of the previous step
  // is read out of the accumulator while phase is low.
  typedef enum logic [3:0] {
    ST_MUL_L   = 4'd0,   // left count delta times distance per count
    ST_MUL_R   = 4'd1,   // right count delta times distance per count
    ST_MUL_G   = 4'd2,   // reciprocal track width times 2^32/pi
    ST_SUMS    = 4'd3,   // mean travel and travel difference
    ST_MUL_D0  = 4'd4,   // mean travel times gain compensation, low half
    ST_MUL_D1  = 4'd5,   // same, high half
    ST_MUL_H00 = 4'd6,   // travel difference times heading gain, four parts
    ST_MUL_H01 = 4'd7,
    ST_MUL_H10 = 4'd8,
    ST_MUL_H11 = 4'd9,
    ST_TURN    = 4'd10,  // heading change and half change
    ST_FOLD    = 4'd11   // midpoint heading, quadrant fold, rotator start
  } step_t;

  state_t state, state_next;
  step_t  step;
  logic   phase;

  logic [31:0] dist_per_count;
  logic [31:0] inv_track_width;

  logic [31:0] prev_left;
  logic [31:0] prev_right;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] heading;

  // Per-update working registers.
  logic [31:0]          dl_mag, dr_mag;
  logic                 dl_neg, dr_neg;
  logic signed [47:0]   lt, rt;
  logic [63:0]          gain;
  logic [47:0]          dist_mag;
  logic                 dist_neg;
  logic [48:0]          diff_mag;
  logic                 diff_neg;
  logic signed [XW-1:0] x0;
  logic [31:0]          full_turn;
  logic [31:0]          half_turn;

  // Shared multiplier.
  mac_ctl_t        mac_ctl;
  logic [31:0]     mac_a, mac_b;
  logic [AccW-1:0] acc;
  logic            mul_step;

  // Rotator.
  logic                 cordic_start;
  logic                 cordic_done;
  logic signed [XW-1:0] cordic_x, cordic_y;
  logic signed [XW-1:0] x_start;
  logic [31:0]          z_start;
  logic [31:0]          mid;
  logic                 fold;

  logic        accept;
  logic        out_free;
  logic [31:0] dl, dr;

  // Combinational capture values.
  logic [63:0]   lt_full, rt_full;
  logic [48:0]   sum_lr, diff_lr;
  logic [47:0]   dist_s;
  logic [XW-1:0] x0_mag;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Adds the scaled rotator output (floor shift by 8) to a position and
  // clamps to the signed 32-bit range.
  function automatic logic [31:0] sat_add(input logic [31:0] p, input logic [XW-1:0] v);
    logic [XW:0]    s;
    logic [XW-31:0] top;
    logic [31:0]    r;
    s   = {{(XW+1-32){p[31]}}, p} + {{9{v[XW-1]}}, v[XW-1:8]};
    top = s[XW:31];
    if ((&top) || !(|top)) begin
      r = s[31:0];
    end else if (s[XW]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    mac_a    = '0;
    mac_b    = '0;
    mul_step = 1'b1;
    mac_ctl  = '{mul: 1'b0, acc: 1'b0, clr: 1'b0, sh: SH_0};
    case (step)
      ST_MUL_L: begin
        mac_a       = dl_mag;
        mac_b       = dist_per_count;
        mac_ctl.clr = 1'b1;
      end
      ST_MUL_R: begin
        mac_a       = dr_mag;
        mac_b       = dist_per_count;
        mac_ctl.clr = 1'b1;
      end
      ST_MUL_G: begin
        mac_a       = inv_track_width;
        mac_b       = InvPiBam;
        mac_ctl.clr = 1'b1;
      end
      ST_MUL_D0: begin
        mac_a       = dist_mag[31:0];
        mac_b       = CordicGain;
        mac_ctl.clr = 1'b1;
      end
      ST_MUL_D1: begin
        mac_a      = {16'b0, dist_mag[47:32]};
        mac_b      = CordicGain;
        mac_ctl.sh = SH_32;
      end
      ST_MUL_H00: begin
        mac_a       = diff_mag[31:0];
        mac_b       = gain[31:0];
        mac_ctl.clr = 1'b1;
      end
      ST_MUL_H01: begin
        mac_a      = diff_mag[31:0];
        mac_b      = gain[63:32];
        mac_ctl.sh = SH_32;
      end
      ST_MUL_H10: begin
        mac_a      = {15'b0, diff_mag[48:32]};
        mac_b      = gain[31:0];
        mac_ctl.sh = SH_32;
      end
      ST_MUL_H11: begin
        mac_a      = {15'b0, diff_mag[48:32]};
        mac_b      = gain[63:32];
        mac_ctl.sh = SH_64;
      end
      default: begin
        mul_step = 1'b0;
      end
    endcase
    mac_ctl.mul = (state == S_MUL) && !phase && mul_step;
    mac_ctl.acc = (state == S_MUL) && phase && mul_step;
  end

  ddo_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  // Accumulator read-out and the small arithmetic between products.
  always_comb begin
    dl      = left_count - prev_left;
    dr      = right_count - prev_right;
    lt_full = dl_neg ? (64'd0 - acc[63:0]) : acc[63:0];
    rt_full = dr_neg ? (64'd0 - acc[63:0]) : acc[63:0];
    sum_lr  = {lt[47], lt} + {rt[47], rt};
    diff_lr = {rt[47], rt} - {lt[47], lt};
    dist_s  = sum_lr[48:1];
    x0_mag  = {{(XW-56){1'b0}}, acc[79:24]};
    // Past a quarter turn the vector is negated and the angle moved by pi,
    // which for a binary angle is a flip of its top bit.
    mid     = heading + half_turn;
    fold    = ($signed(mid) > $signed(32'h4000_0000)) ||
              ($signed(mid) < $signed(32'hC000_0000));
    z_start = fold ? {~mid[31], mid[30:0]} : mid;
    x_start = fold ? -x0 : x0;
  end

  assign cordic_start = (state == S_MUL) && (step == ST_FOLD);

  ddo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .x_in  (x_start),
    .z_in  (z_start),
    .done  (cordic_done),
    .x_out (cordic_x),
    .y_out (cordic_y)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = operation ? S_PUB : S_MUL;
        end
      end
      S_MUL: begin
        if (step == ST_FOLD) begin
          state_next = S_ROT;
        end
      end
      S_ROT: begin
        if (cordic_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = S_PUB;
      end
      S_PUB: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state, configuration and pose.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      step            <= ST_MUL_L;
      phase           <= 1'b0;
      out_valid       <= 1'b0;
      dist_per_count  <= DistPerCountRst;
      inv_track_width <= InvTrackWidthRst;
      prev_left       <= '0;
      prev_right      <= '0;
      pos_x           <= '0;
      pos_y           <= '0;
      heading         <= '0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        if (cfg_index == REG_DIST_PER_COUNT) begin
          dist_per_count <= cfg_data;
        end else begin
          inv_track_width <= cfg_data;
        end
      end

      if (state == S_MUL) begin
        phase <= !phase;
        if (phase) begin
          step <= step_t'(step + 1'b1);
        end
      end else begin
        phase <= 1'b0;
        step  <= ST_MUL_L;
      end

      if (accept) begin
        if (operation) begin
          prev_left  <= '0;
          prev_right <= '0;
          pos_x      <= '0;
          pos_y      <= '0;
          heading    <= '0;
        end else begin
          prev_left  <= left_count;
          prev_right <= right_count;
        end
      end

      if (state == S_FIN) begin
        pos_x   <= sat_add(pos_x, cordic_x);
        pos_y   <= sat_add(pos_y, cordic_y);
        heading <= heading + full_turn;
      end

      if ((state == S_PUB) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and the output word; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      dl_mag <= dl[31] ? (32'd0 - dl) : dl;
      dl_neg <= dl[31];
      dr_mag <= dr[31] ? (32'd0 - dr) : dr;
      dr_neg <= dr[31];
    end
    if ((state == S_MUL) && !phase) begin
      case (step)
        ST_MUL_R: begin
          lt <= $signed(lt_full[63:16]);
        end
        ST_MUL_G: begin
          rt <= $signed(rt_full[63:16]);
        end
        ST_SUMS: begin
          gain     <= acc[63:0];
          dist_neg <= dist_s[47];
          dist_mag <= dist_s[47] ? (48'd0 - dist_s) : dist_s;
          diff_neg <= diff_lr[48];
          diff_mag <= diff_lr[48] ? (49'd0 - diff_lr) : diff_lr;
        end
        ST_MUL_H00: begin
          x0 <= dist_neg ? -$signed(x0_mag) : $signed(x0_mag);
        end
        ST_TURN: begin
          full_turn <= diff_neg ? (32'd0 - acc[72:41]) : acc[72:41];
          half_turn <= diff_neg ? (32'd0 - acc[73:42]) : acc[73:42];
        end
        default: begin
        end
      endcase
    end
    if ((state == S_PUB) && out_free) begin
      pos_x_out   <= pos_x;
      pos_y_out   <= pos_y;
      heading_out <= heading;
    end
  end

  // The rotator only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) cordic_done |-> (state == S_ROT))
    else $error("rotator finished outside the rotation phase");

  // A new output word only ever comes from the publish state.
  assert property (@(posedge clk) disable iff (rst)
      $rose(out_valid) |-> $past(state == S_PUB))
    else $error("output word appeared without being published");

  // A reset operation clears the pose by the next cycle and goes to publish.
  assert property (@(posedge clk) disable iff (rst)
      (accept && operation) |=> (state == S_PUB && pos_x == '0 && pos_y == '0 &&
                                 heading == '0))
    else $error("reset operation did not clear the pose");

  // The rotator is started exactly once per update, from the multiply phase.
  assert property (@(posedge clk) disable iff (rst)
      cordic_start |=> (state == S_ROT && !cordic_start))
    else $error("rotator start out of sequence");

endmodule

>>> src/ddo_mac.sv
// Shared 32x32 multiplier with a shifting 80-bit accumulator.
// Depends on ddo_pkg for the control struct and widths.
module ddo_mac
  import ddo_pkg::*;
(
  input  logic            clk,
  input  mac_ctl_t        ctl,
  input  logic [31:0]     a,
  input  logic [31:0]     b,
  output logic [AccW-1:0] acc
);

  logic [63:0]     prod;
  logic [AccW-1:0] addend;
  logic [AccW-1:0] base;

  always_comb begin
    case (ctl.sh)
      SH_0:    addend = AccW'(prod);
      SH_32:   addend = AccW'(prod) << 32;
      SH_64:   addend = AccW'(prod) << 64;
      default: addend = '0;
    endcase
    base = ctl.clr ? '0 : acc;
  end

  // The product is registered, then added in the following cycle.
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= 64'(a) * 64'(b);
    end
    if (ctl.acc) begin
      acc <= base + addend;
    end
  end

endmodule

>>> src/ddo_cordic.sv
// Iterative CORDIC rotator: one micro-rotation per clock, y starts at zero.
// Depends on ddo_pkg for the widths and the arctangent table.
module ddo_cordic
  import ddo_pkg::*;
#(
  parameter int STEPS = CordicStepsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [XW-1:0] x_in,
  input  logic [31:0]          z_in,
  output logic                 done,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out
);

  localparam int CntW = $clog2(STEPS);

  logic                 active;
  logic [CntW-1:0]      cnt;
  logic signed [ZW-1:0] z;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] ang;

  always_comb begin
    xs  = x_out >>> cnt;
    ys  = y_out >>> cnt;
    ang = $signed({{(ZW-32){1'b0}}, atan_bam(AtanIdxW'(cnt))});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_out <= x_in;
      y_out <= '0;
      z     <= $signed({{(ZW-32){z_in[31]}}, z_in});
    end else if (active) begin
      if (!z[ZW-1]) begin
        x_out <= x_out - ys;
        y_out <= y_out + xs;
        z     <= z - ang;
      end else begin
        x_out <= x_out + ys;
        y_out <= y_out - xs;
        z     <= z + ang;
      end
    end
  end

endmodule

>>> tb/odometry_check_pkg.sv
// Pose tracker for the differential drive odometry testbench: own copy of the
// pose arithmetic and a queue of expected pose words. Depends on ddo_pkg.
package odometry_check_pkg;
  import ddo_pkg::*;

  localparam int RotSteps = 24;
  localparam logic [31:0] RecipPiBam = 32'd1367130551;
  localparam logic [31:0] GainComp = 32'd2608131496;
  localparam logic [31:0] DistDefault = 32'd2147484;
  localparam logic [31:0] RecipDefault = 32'd83886080;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } odo_op_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] h;
  } pose_word_t;

  class pose_tracker;
    logic [31:0] dist_per_count;
    logic [31:0] inv_track_width;
    logic [31:0] last_left;
    logic [31:0] last_right;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic [31:0] atan_tab [32];
    pose_word_t expected_poses[$];
    int errors;

    function new();
      atan_tab = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000};
      dist_per_count = DistDefault;
      inv_track_width = RecipDefault;
      clear_pose();
      errors = 0;
    endfunction

    function void clear_pose();
      last_left = '0;
      last_right = '0;
      pos_x = '0;
      pos_y = '0;
      heading = '0;
    endfunction

    function void write_register(logic idx, logic [31:0] value);
      if (idx == REG_DIST_PER_COUNT) dist_per_count = value;
      else inv_track_width = value;
    endfunction

    // Signed count difference times distance per count, floored to Q.16.
    function longint wheel_travel(logic [31:0] now, logic [31:0] last);
      logic signed [31:0] d;
      longint ds;
      logic [63:0] mag;
      d = now - last;
      ds = d;
      mag = (ds < 0) ? -ds : ds;
      mag = mag * {32'd0, dist_per_count};
      ds = (d < 0) ? -longint'(mag) : longint'(mag);
      return ds >>> 16;
    endfunction

    function logic [31:0] clamp_add(logic [31:0] p, longint delta);
      longint s;
      s = longint'($signed(p)) + delta;
      if (s > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (s < -64'sd2147483648) return 32'h8000_0000;
      return s[31:0];
    endfunction

    function void advance_pose(odo_op_t op, logic [31:0] lc, logic [31:0] rc);
      longint lt, rt, avg, diff, x, y, z, xs, ys;
      logic [63:0] gain, mag;
      logic [127:0] prod;
      logic [31:0] full, half, mid;
      pose_word_t w;
      if (op == OP_CLEAR) begin
        clear_pose();
      end else begin
        lt = wheel_travel(lc, last_left);
        rt = wheel_travel(rc, last_right);
        last_left = lc;
        last_right = rc;
        avg = (lt + rt) >>> 1;
        diff = rt - lt;

        // Heading change in binary angle, magnitude truncated, then signed.
        gain = {32'd0, inv_track_width} * {32'd0, RecipPiBam};
        mag = (diff < 0) ? -diff : diff;
        prod = {64'd0, mag} * {64'd0, gain};
        full = prod[72:41];
        half = prod[73:42];
        if (diff < 0) begin
          full = -full;
          half = -half;
        end
        mid = heading + half;

        // Gain-compensated travel as the rotator's starting vector.
        mag = (avg < 0) ? -avg : avg;
        prod = {64'd0, mag} * {96'd0, GainComp};
        x = prod[87:24];
        if (avg < 0) x = -x;
        y = 0;

        // Fold angles beyond a quarter turn back by half a turn.
        if ($signed(mid) > 32'sd1073741824 || $signed(mid) < -32'sd1073741824) begin
          x = -x;
          mid = mid - 32'h8000_0000;
        end
        z = $signed(mid);
        for (int k = 0; k < RotSteps; k++) begin
          xs = x >>> k;
          ys = y >>> k;
          if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(atan_tab[k]);
          end else begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(atan_tab[k]);
          end
        end

        pos_x = clamp_add(pos_x, x >>> 8);
        pos_y = clamp_add(pos_y, y >>> 8);
        heading = heading + full;
      end
      w.x = pos_x;
      w.y = pos_y;
      w.h = heading;
      expected_poses.push_back(w);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
    endfunction

    function void compare_pose(logic [31:0] x, logic [31:0] y, logic [31:0] h);
      pose_word_t e;
      if (expected_poses.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual x %h y %h heading %h",
                 $time, x, y, h);
        return;
      end
      e = expected_poses.pop_front();
      if (x !== e.x) flag("pos_x_out", e.x, x);
      if (y !== e.y) flag("pos_y_out", e.y, y);
      if (h !== e.h) flag("heading_out", e.h, h);
    endfunction

    function int pending();
      return expected_poses.size();
    endfunction
  endclass

endpackage

>>> tb/tb.sv
// Top-level testbench for differential_drive_odometry: clock, reset, stimulus,
// output monitor and run limit. Depends on ddo_pkg and odometry_check_pkg.
module tb;
  import ddo_pkg::*;
  import odometry_check_pkg::*;

  logic clk;
  logic rst;
  logic cfg_write;
  logic cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic operation;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] pos_x_out;
  logic signed [31:0] pos_y_out;
  logic signed [31:0] heading_out;

  // Flags raised by the stimulus: one long receiver hold-off, and a stretch
  // in which neither side idles.
  logic pressure_go;
  logic quiet;

  // Counts most recently sent (zero after a clear), used to build realistic small steps.
  logic [31:0] cur_left;
  logic [31:0] cur_right;

  pose_tracker poses;

  differential_drive_odometry #(
    .CORDIC_STEPS(RotSteps)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .left_count(left_count),
    .right_count(right_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pos_x_out(pos_x_out),
    .pos_y_out(pos_y_out),
    .heading_out(heading_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The run limit allows several times the slowest legal run: every word
  // waiting out the full pipeline, the longest sender gap and receiver stall.
  initial begin
    #4800000;
    $display("status: fail");
    $finish;
  end

  // Output monitor. Signals read right after the edge still hold the values
  // they had at the edge, since everything is updated with nonblocking writes.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      poses.compare_pose(pos_x_out, pos_y_out, heading_out);
  end

  // Receiver. It stalls at random about a quarter of the time, not at all
  // while the quiet stretch is on, and once holds off so long that the block
  // fills up and must stall its own input.
  initial begin
    int unsigned hold;
    bit held;
    out_stall = 1'b0;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        out_stall <= 1'b1;
        hold--;
      end else if (pressure_go && !held) begin
        held = 1'b1;
        hold = 399;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 26);
      end
    end
  end

  // Offer one word and wait until it is taken. Valid is left high after the
  // handshake so that back-to-back words never lower and raise it in one step;
  // a gap before the next word is what lowers it.
  task automatic send_word(input odo_op_t op, input logic [31:0] lc,
                           input logic [31:0] rc);
    int unsigned gap;
    if (!quiet && $urandom_range(99) < 26) begin
      // Mostly short gaps, now and then a longer one that may outlast the whole
      // pipeline, so that idle cycles land on every phase of the block's work.
      gap = ($urandom_range(9) == 0) ? $urandom_range(70, 1) : $urandom_range(3, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operation <= op;
    left_count <= lc;
    right_count <= rc;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    poses.advance_pose(op, lc, rc);
    if (op == OP_CLEAR) begin
      cur_left = '0;
      cur_right = '0;
    end else begin
      cur_left = lc;
      cur_right = rc;
    end
  endtask

  // Registers are written only once the block has handed back every word.
  task automatic load_settings(input logic [31:0] dpc, input logic [31:0] itw);
    in_valid <= 1'b0;
    while (poses.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_DIST_PER_COUNT;
    cfg_data <= dpc;
    @(posedge clk);
    poses.write_register(REG_DIST_PER_COUNT, dpc);
    cfg_index <= REG_INV_TRACK_WIDTH;
    cfg_data <= itw;
    @(posedge clk);
    poses.write_register(REG_INV_TRACK_WIDTH, itw);
    cfg_write <= 1'b0;
  endtask

  // Mostly small steps from the last counts, as a real encoder gives, with
  // larger jumps, fully random counts and an occasional pose clear mixed in.
  task automatic random_word();
    int unsigned pick;
    int dl;
    int dr;
    odo_op_t op;
    logic [31:0] lc;
    logic [31:0] rc;
    pick = $urandom_range(99);
    op = (pick < 5) ? OP_CLEAR : OP_UPDATE;
    if (pick < 20) begin
      lc = $urandom;
      rc = $urandom;
    end else if (pick < 45) begin
      dl = int'($urandom_range(2097152)) - 1048576;
      dr = int'($urandom_range(2097152)) - 1048576;
      lc = cur_left + dl;
      rc = cur_right + dr;
    end else begin
      dl = int'($urandom_range(10000)) - 5000;
      dr = dl + int'($urandom_range(2000)) - 1000;
      lc = cur_left + dl;
      rc = cur_right + dr;
    end
    send_word(op, lc, rc);
  endtask

  initial begin
    int ph;
    int n;
    poses = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_DIST_PER_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = OP_UPDATE;
    left_count = '0;
    right_count = '0;
    pressure_go = 1'b0;
    quiet = 1'b0;
    cur_left = '0;
    cur_right = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at the reset settings: standing still, straight runs,
    // turns far enough that the midpoint heading passes a quarter turn,
    // count extremes and their wrap, a clear carrying counts that must be
    // ignored, driving backward and a spin whose heading change wraps.
    send_word(OP_CLEAR, 32'd0, 32'd0);
    send_word(OP_UPDATE, 32'd0, 32'd0);
    send_word(OP_UPDATE, 32'd1000, 32'd1000);
    send_word(OP_UPDATE, 32'd1900, 32'd2100);
    send_word(OP_UPDATE, -32'sd3000, 32'd5000);
    send_word(OP_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(OP_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_UPDATE, -32'sd200000, 32'd200000);
    send_word(OP_UPDATE, -32'sd200000, 32'd200000);
    send_word(OP_UPDATE, -32'sd300000, -32'sd100000);

    // Largest settings: a single step saturates position at both ends.
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_CLEAR, 32'd0, 32'd0);
    send_word(OP_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(OP_UPDATE, 32'd0, 32'd0);
    send_word(OP_UPDATE, 32'h1234_5678, 32'hFFFF_FFFF);

    // Smallest settings: travel rounds down to nothing or almost nothing.
    load_settings(32'd1, 32'd1);
    send_word(OP_CLEAR, 32'd0, 32'd0);
    send_word(OP_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(OP_UPDATE, 32'd0, 32'd0);

    // Random phases, each under its own settings.
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_settings($urandom_range(40000000, 200000),
                         $urandom_range(134217728, 8388608));
        1: load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: load_settings(32'd1, 32'd1);
        3: load_settings($urandom_range(32'hFFFF_FFFF, 1),
                         $urandom_range(32'hFFFF_FFFF, 1));
        default: load_settings($urandom_range(40000000, 200000),
                               $urandom_range(134217728, 8388608));
      endcase
      if (ph == 0) pressure_go <= 1'b1;
      if (ph == 4) quiet = 1'b1;
      for (n = 0; n < 110; n++) random_word();
      quiet = 1'b0;
    end

    in_valid <= 1'b0;
    while (poses.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (poses.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
src/ddo_pkg.sv
src/ddo_mac.sv
src/ddo_cordic.sv
src/differential_drive_odometry.sv
tb/odometry_check_pkg.sv
tb/tb.sv
